/* rtl/mes_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mes_pkg;
	localparam int SampleBits = 24;
	localparam int GainBits = 16;
	localparam int Win = 9;
	localparam int CntBits = 4;
	localparam logic [GainBits-1:0] GainReset = 16'd19661;

	// One median job: window contents, its length and whether it closes the run.
	typedef struct packed {
		logic [Win-1:0][SampleBits-1:0] win;
		logic [CntBits-1:0]             n;
		logic                           last;
	} job_t;
endpackage
`default_nettype wire

/* rtl/mes_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mes_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [mes_pkg::SampleBits-1:0]  sample_value,
	input  wire                            is_last,
	output logic                           job_valid,
	input  wire                            job_stall,
	output mes_pkg::job_t                  job
);
	import mes_pkg::*;

	logic [Win-1:0][SampleBits-1:0] win_q;
	logic [CntBits-1:0]             held_q;
	logic                           flush_q;
	logic [Win-1:0][SampleBits-1:0] ins;
	logic [CntBits-1:0]             nins;

	// Window after taking the new sample, with the oldest dropped when full.
	always_comb begin
		ins = win_q;
		nins = held_q;
		if (held_q == CntBits'(Win)) begin
			for (int i = 0; i < Win - 1; i++) ins[i] = win_q[i+1];
			nins = CntBits'(Win - 1);
		end
		ins[nins] = sample_value;
		nins = nins + 1'b1;
	end

	// While flushing, one job per cycle unless the back end stalls, with a shrinking window.
	always_comb begin
		in_stall = flush_q;
		job_valid = 1'b0;
		job.win = ins;
		job.n = nins;
		job.last = 1'b0;
		if (flush_q) begin
			job_valid = 1'b1;
			job.win = win_q;
			job.n = held_q;
			job.last = (held_q == CntBits'(1));
		end else if (in_valid) begin
			job_valid = is_last || (nins == CntBits'(Win));
			job.last = is_last && (nins == CntBits'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			held_q <= '0;
			flush_q <= 1'b0;
		end else if (!job_stall) begin
			if (flush_q) begin
				for (int i = 0; i < Win - 1; i++) win_q[i] <= win_q[i+1];
				held_q <= held_q - 1'b1;
				if (held_q == CntBits'(1)) flush_q <= 1'b0;
			end else if (in_valid) begin
				if (is_last) begin
					for (int i = 0; i < Win - 1; i++) win_q[i] <= ins[i+1];
					held_q <= nins - 1'b1;
					flush_q <= (nins != CntBits'(1));
				end else begin
					win_q <= ins;
					held_q <= nins;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/mes_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mes_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [mes_pkg::GainBits-1:0]    gain,
	input  wire                            job_valid,
	output logic                           job_stall,
	input  wire mes_pkg::job_t             job,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [mes_pkg::SampleBits-1:0] smoothed_value,
	output logic                           end_of_run
);
	import mes_pkg::*;

	logic [CntBits-1:0] rank [Win];
	logic [SampleBits-1:0] med;
	logic                  busy_q;
	logic [SampleBits-1:0] med_s1;
	logic                  last_s1;
	logic [SampleBits-1:0] prev_q;
	logic                  first_q;
	logic signed [SampleBits:0]          diff;
	logic signed [SampleBits+GainBits+1:0] prod;
	logic [SampleBits-1:0] y;

	// Rank selection: element whose count of smaller (or equal earlier) entries is n/2.
	always_comb begin
		med = '0;
		for (int i = 0; i < Win; i++) begin
			rank[i] = '0;
			for (int j = 0; j < Win; j++)
				if (j != i && CntBits'(j) < job.n &&
				    (job.win[j] < job.win[i] || (job.win[j] == job.win[i] && j < i)))
					rank[i] = rank[i] + 1'b1;
			if (CntBits'(i) < job.n && rank[i] == (job.n >> 1)) med = job.win[i];
		end
	end

	// Low-pass step: floor of gain times difference, added to the previous output.
	always_comb begin
		diff = $signed({1'b0, med_s1}) - $signed({1'b0, prev_q});
		prod = diff * $signed({1'b0, gain});
		y = first_q ? med_s1 : SampleBits'($signed({2'b0, prev_q}) + (prod >>> GainBits));
	end

	assign job_stall = busy_q && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			med_s1 <= '0;
			last_s1 <= 1'b0;
			out_valid <= 1'b0;
			smoothed_value <= '0;
			end_of_run <= 1'b0;
			prev_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (busy_q && !(out_valid && out_stall)) begin
				smoothed_value <= y;
				end_of_run <= last_s1;
				out_valid <= 1'b1;
				prev_q <= last_s1 ? '0 : y;
				first_q <= last_s1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (!job_stall) begin
				busy_q <= job_valid;
				med_s1 <= med;
				last_s1 <= job.last;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/median_then_ema_smoother_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Forward nine-sample median, then a first-order low-pass. A sample is taken each
// cycle unless stalled; each result passes a median register and an output register.
// A last sample flushes the window, up to eight more results, one per cycle unless
// output stalls, input stalled. User must write smoothing gain only while idle; unenforced.
module median_then_ema_smoother_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [mes_pkg::SampleBits-1:0]  sample_value,
	input  wire                            is_last,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [mes_pkg::SampleBits-1:0] smoothed_value,
	output logic                           end_of_run,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [mes_pkg::GainBits-1:0]    cfg_data
);
	import mes_pkg::*;

	logic [GainBits-1:0] gain_q;
	logic  job_valid, job_stall, fstall;
	job_t  job;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= GainReset;
		else if (cfg_valid) gain_q <= cfg_data;
	end

	assign in_stall = fstall || job_stall;

	mes_front u_front (
		.clk, .arst_n, .in_valid, .in_stall(fstall), .sample_value, .is_last,
		.job_valid, .job_stall, .job
	);

	mes_back u_back (
		.clk, .arst_n, .gain(gain_q), .job_valid, .job_stall, .job,
		.out_valid, .out_stall, .smoothed_value, .end_of_run
	);
endmodule
`default_nettype wire

/* dv/median_then_ema_smoother_unit_tb.sv */
`timescale 1ns / 1ps
module median_then_ema_smoother_unit_tb;
	import mes_pkg::*;

	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic [SampleBits-1:0] value;
		logic                  eor;
	} smoothed_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	wire                   in_stall;
	logic [SampleBits-1:0] sample_value = '0;
	logic                  is_last = 1'b0;
	wire                   out_valid;
	logic                  out_stall = 1'b0;
	wire [SampleBits-1:0]  smoothed_value;
	wire                   end_of_run;
	logic                  cfg_valid = 1'b0;
	wire                   cfg_ready;
	logic [GainBits-1:0]   cfg_data = '0;

	median_then_ema_smoother_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_value(sample_value), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.smoothed_value(smoothed_value), .end_of_run(end_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state, a mirror of the block's window and smoother.
	logic [SampleBits-1:0] held_samples [Win];
	int                    held_n = 0;
	logic [SampleBits-1:0] last_smoothed = '0;
	logic                  first_pending = 1'b1;
	logic [GainBits-1:0]   gain = GainReset;
	smoothed_t             expected_q [$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  runs_sent = 0;
	int  cycles = 0;
	int  hold_off = 0;
	bit  stall_enable = 1'b1;

	function automatic logic [SampleBits-1:0] median_of(int n);
		logic [SampleBits-1:0] t [Win];
		logic [SampleBits-1:0] v;
		int b;
		for (int a = 0; a < n; a++) t[a] = held_samples[a];
		for (int a = 1; a < n; a++) begin
			v = t[a];
			b = a;
			while (b > 0 && t[b-1] > v) begin
				t[b] = t[b-1];
				b--;
			end
			t[b] = v;
		end
		return t[n/2];
	endfunction

	function automatic logic [SampleBits-1:0] smooth_next(logic [SampleBits-1:0] m);
		longint diff, prod, q;
		if (first_pending) begin
			first_pending = 1'b0;
			last_smoothed = m;
		end else begin
			diff = longint'(m) - longint'(last_smoothed);
			prod = diff * longint'(gain);
			q = prod >>> 16;
			last_smoothed = SampleBits'(longint'(last_smoothed) + q);
		end
		return last_smoothed;
	endfunction

	function automatic void shift_out_oldest();
		for (int k = 1; k < held_n; k++) held_samples[k-1] = held_samples[k];
		if (held_n > 0) held_n--;
	endfunction

	// Appends one expected result at the tail of the queue.
	function automatic void add_expected(smoothed_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	// Works out the results one accepted sample causes.
	function automatic void predict_sample(logic [SampleBits-1:0] s, logic lst);
		smoothed_t r;
		if (held_n >= Win) shift_out_oldest();
		held_samples[held_n] = s;
		held_n++;
		if (!lst) begin
			if (held_n == Win) begin
				r.value = smooth_next(median_of(held_n));
				r.eor = 1'b0;
				add_expected(r);
				shift_out_oldest();
			end
		end else begin
			while (held_n > 0) begin
				r.value = smooth_next(median_of(held_n));
				shift_out_oldest();
				r.eor = (held_n == 0);
				add_expected(r);
			end
			last_smoothed = '0;
			first_pending = 1'b1;
		end
	endfunction

	// Cycle counter and limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver stall at random, with a long hold-off when a test sets one.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else if (!stall_enable) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: out_stall <= 1'b1;
				4: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		smoothed_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: value %h eor %b", smoothed_value, end_of_run);
			end else begin
				exp_r = expected_q.pop_front();
				if (smoothed_value !== exp_r.value || end_of_run !== exp_r.eor) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected value %h eor %b, got %h eor %b",
							exp_r.value, exp_r.eor, smoothed_value, end_of_run);
				end
			end
		end
	end

	// Sends one sample transaction, with a random gap before it unless told otherwise.
	task automatic send_sample(logic [SampleBits-1:0] s, logic lst, bit no_gap = 1'b0);
		int gap;
		if (!no_gap) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
				: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		sample_value <= s;
		is_last <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_sample(s, lst);
		items_sent++;
		if (lst) runs_sent++;
	endtask

	task automatic send_idle();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		send_idle();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_gain(logic [GainBits-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gain = g;
	endtask

	function automatic logic [SampleBits-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return SampleBits'($urandom_range(0, 255));
			3: return ~SampleBits'($urandom_range(0, 255));
			default: return SampleBits'($urandom);
		endcase
	endfunction

	task automatic send_run(int len);
		for (int k = 0; k < len; k++) send_sample(random_sample(), k == len - 1);
	endtask

	// Directed: extremes, short runs, a run of exactly one window, default gain.
	task automatic test_directed();
		send_sample('0, 1'b1);
		send_sample('1, 1'b1);
		send_sample('1, 1'b0);
		send_sample('0, 1'b1);
		for (int k = 0; k < 9; k++) send_sample(k[0] ? '1 : '0, k == 8);
		for (int k = 0; k < 10; k++) send_sample(SampleBits'(k * 24'h155555), k == 9);
		wait_drained();
	endtask

	// Gain extremes: zero holds the first median, full scale nearly tracks.
	task automatic test_gain_extremes();
		write_gain('0);
		send_run(12);
		wait_drained();
		write_gain('1);
		send_run(12);
		wait_drained();
		write_gain(16'h8000);
		send_run(5);
		wait_drained();
	endtask

	// Long hold-off on the output while input keeps being offered.
	task automatic test_backpressure();
		hold_off = 200;
		for (int k = 0; k < 40; k++) send_sample(random_sample(), k == 39, 1'b1);
		wait_drained();
	endtask

	// Random runs of mostly moderate length, with gain changes between phases.
	task automatic test_random_runs();
		int len;
		for (int phase = 0; phase < 4; phase++) begin
			write_gain(GainBits'($urandom));
			while (items_sent < 80 + (phase + 1) * 85) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9)
					: $urandom_range(10, 40);
				send_run(len);
			end
			if (phase == 2) stall_enable = 1'b0;
			wait_drained();
			stall_enable = 1'b1;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_gain_extremes();
		test_backpressure();
		test_random_runs();
		wait_drained();
		$display("Covered %0d samples in %0d runs, %0d results checked, gain extremes",
			items_sent, runs_sent, results_seen);
		$display("and a long output hold-off with the input held back.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
